// ===== src/gc_mark_bitmap_epoch_assert.svh =====
// Assertion macros for the mark bitmap block.
// Each expects clk and arst_n in scope at the place of use.
`ifndef GC_MARK_BITMAP_EPOCH_ASSERT_SVH
`define GC_MARK_BITMAP_EPOCH_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define GCMBE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gc mark bitmap check failed");

// Next-cycle implication.
`define GCMBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gc mark bitmap check failed");

`endif

// ===== src/gcmbe_pkg.sv =====
`timescale 1ns / 1ps
package gcmbe_pkg;

	localparam int OBJ_W  = 12;
	localparam int WIDX_W = 6;

	localparam logic [1:0] REQ_MARK = 2'd0;
	localparam logic [1:0] REQ_TEST = 2'd1;
	localparam logic [1:0] REQ_ADD  = 2'd2;
	localparam logic [1:0] REQ_SCAN = 2'd3;

	// register word index (paddr[2])
	localparam logic REG_GLOBAL_EPOCH = 1'b0;

	localparam logic [31:0] OBJ_SAT  = 32'hFFFF_FFFF;
	localparam logic [39:0] BYTE_SAT = 40'hFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [OBJ_W-1:0]  obj_index;
		logic [WIDX_W-1:0] word_index;
		logic [12:0]       add_objects;
		logic [31:0]       add_bytes;
	} req_t;

	typedef struct packed {
		logic             bit_value;
		logic             epoch_current;
		logic             found;
		logic [OBJ_W-1:0] found_index;
		logic [31:0]      live_objects;
		logic [39:0]      live_bytes;
		logic             last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ADDR,
		ST_DATA,
		ST_ADD,
		ST_SCAN
	} state_t;

endpackage

// ===== src/gc_mark_bitmap_epoch.sv =====
`timescale 1ns / 1ps
// Channel   | Handshake                          | Payload
// ----------+------------------------------------+---------------------------
// request   | start, busy (beat: start & !busy)  | req    (gcmbe_pkg::req_t)
// result    | done, one cycle, no back-pressure  | result (gcmbe_pkg::res_t)
// config    | APB psel/penable/pwrite, pready=1  | paddr, pwdata, prdata
//
// Steps: add holds busy in its add state; mark and test pass the divide,
// address and data states, mark doing its read-modify-write through the
// single-port-write bitmap RAM. A scan fetches the word in its address and
// data states, then walks the bit positions up to the highest set bit, one bit
// a cycle through the shift/count unit; an empty word gives its single result after the fetch.
// Reset: asynchronous, clears counters, the stored epoch and all row valid bits
// at once (the global epoch resets to 1), so the bitmap reads as zero with no
// clearing pass. A stale-epoch mark does the same lazy clear at its accept beat.
// Stalls: the receiver cannot stall; results leave from a register.
module gc_mark_bitmap_epoch #(
	parameter int MAP_BITS  = 4096,
	parameter int WORD_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  gcmbe_pkg::req_t  req,
	output logic             done,
	output gcmbe_pkg::res_t  result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

`include "gc_mark_bitmap_epoch_assert.svh"

	localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int XW        = (AW > gcmbe_pkg::OBJ_W) ? AW : gcmbe_pkg::OBJ_W;
	localparam int JW        = $clog2(WORD_BITS);
	// floor(obj * RECIP / 2^24) is exact for 12-bit slots and divisors up to 64
	localparam int RECIP_SH  = 24;
	localparam int RECIP     = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int PROD_W    = gcmbe_pkg::OBJ_W + RECIP_SH;

	// Control state
	gcmbe_pkg::state_t     state_q, state_d;
	logic [31:0]           global_epoch_q;
	logic [31:0]           stored_epoch_q;
	logic [31:0]           obj_total_q;
	logic [39:0]           byte_total_q;
	logic [NUM_WORDS-1:0]  row_valid_q;
	logic                  done_q;

	// Item payload
	gcmbe_pkg::req_t               req_q;
	logic [gcmbe_pkg::OBJ_W-1:0]   quot_q;
	logic [AW-1:0]                 addr_q;
	logic [JW-1:0]                 bit_q;
	logic                          in_range_q;
	logic [WORD_BITS-1:0]          shift_q;
	logic [JW-1:0]                 pos_q;
	gcmbe_pkg::res_t               result_q;

	logic                  accept;
	logic                  cfg_wr;
	logic                  stale_mark;
	logic                  emit;
	gcmbe_pkg::res_t       res_d;
	logic [PROD_W-1:0]     prod;
	logic [gcmbe_pkg::OBJ_W-1:0] rem;
	logic [XW-1:0]         quot_x;
	logic [XW-1:0]         widx_x;
	logic [AW-1:0]         addr_d;
	logic                  in_range_d;
	logic [WORD_BITS-1:0]  word_v;
	logic [32:0]           obj_sum;
	logic [40:0]           byte_sum;
	logic [31:0]           obj_sat;
	logic [39:0]           byte_sat;
	logic [gcmbe_pkg::OBJ_W:0] scan_idx;

	logic                  ram_we;
	logic [AW-1:0]         ram_raddr;
	logic [WORD_BITS-1:0]  ram_wdata;
	logic [WORD_BITS-1:0]  ram_rdata;

	assign accept     = start && !busy;
	assign busy       = (state_q != gcmbe_pkg::ST_IDLE);
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign stale_mark = accept && (req.req_type == gcmbe_pkg::REQ_MARK)
		&& (stored_epoch_q != global_epoch_q);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == gcmbe_pkg::REG_GLOBAL_EPOCH) ? global_epoch_q : 32'd0;

	// Slot to word: reciprocal multiply, then remainder by constant multiply
	assign prod   = PROD_W'(req_q.obj_index) * PROD_W'(RECIP);
	assign rem    = req_q.obj_index - gcmbe_pkg::OBJ_W'(quot_q * WORD_BITS);
	assign quot_x = XW'(quot_q);
	assign widx_x = XW'(req_q.word_index);

	assign addr_d     = (req_q.req_type == gcmbe_pkg::REQ_SCAN) ? widx_x[AW-1:0]
		: quot_x[AW-1:0];
	assign in_range_d = (req_q.req_type == gcmbe_pkg::REQ_SCAN)
		? ({26'd0, req_q.word_index} < 32'(NUM_WORDS))
		: ({20'd0, req_q.obj_index} < 32'(MAP_BITS));

	// Rows never written since the last clear read as zero
	assign word_v = (in_range_q && row_valid_q[addr_q]) ? ram_rdata : '0;

	// Saturating counter update
	assign obj_sum  = {1'b0, obj_total_q} + {20'd0, req_q.add_objects};
	assign byte_sum = {1'b0, byte_total_q} + {9'd0, req_q.add_bytes};
	assign obj_sat  = obj_sum[32] ? gcmbe_pkg::OBJ_SAT : obj_sum[31:0];
	assign byte_sat = byte_sum[40] ? gcmbe_pkg::BYTE_SAT : byte_sum[39:0];

	assign scan_idx = (gcmbe_pkg::OBJ_W + 1)'(req_q.word_index * WORD_BITS)
		+ (gcmbe_pkg::OBJ_W + 1)'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcmbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_raddr = addr_d;
		ram_wdata = word_v | (WORD_BITS'(1) << bit_q);
		emit      = 1'b0;

		res_d               = '0;
		res_d.epoch_current = (stored_epoch_q == global_epoch_q);
		res_d.live_objects  = obj_total_q;
		res_d.live_bytes    = byte_total_q;
		res_d.last          = 1'b1;

		case (state_q)
			gcmbe_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						gcmbe_pkg::REQ_ADD:  state_d = gcmbe_pkg::ST_ADD;
						gcmbe_pkg::REQ_SCAN: state_d = gcmbe_pkg::ST_ADDR;
						default:             state_d = gcmbe_pkg::ST_DIV;
					endcase
				end
			end
			gcmbe_pkg::ST_DIV: begin
				state_d = gcmbe_pkg::ST_ADDR;
			end
			gcmbe_pkg::ST_ADDR: begin
				// read issued here, data lands in the next cycle
				state_d = gcmbe_pkg::ST_DATA;
			end
			gcmbe_pkg::ST_DATA: begin
				case (req_q.req_type)
					gcmbe_pkg::REQ_MARK: begin
						ram_we  = in_range_q;
						emit    = 1'b1;
						state_d = gcmbe_pkg::ST_IDLE;
					end
					gcmbe_pkg::REQ_TEST: begin
						res_d.bit_value = word_v[bit_q];
						emit            = 1'b1;
						state_d         = gcmbe_pkg::ST_IDLE;
					end
					default: begin
						if (word_v == '0) begin
							emit    = 1'b1;
							state_d = gcmbe_pkg::ST_IDLE;
						end else begin
							state_d = gcmbe_pkg::ST_SCAN;
						end
					end
				endcase
			end
			gcmbe_pkg::ST_ADD: begin
				res_d.live_objects = obj_sat;
				res_d.live_bytes   = byte_sat;
				emit               = 1'b1;
				state_d            = gcmbe_pkg::ST_IDLE;
			end
			gcmbe_pkg::ST_SCAN: begin
				res_d.found       = 1'b1;
				res_d.found_index = scan_idx[gcmbe_pkg::OBJ_W-1:0];
				res_d.last        = ((shift_q >> 1) == '0);
				emit              = shift_q[0];
				if (shift_q[0] && res_d.last) begin
					state_d = gcmbe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gcmbe_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_epoch_q <= 32'd1;
			stored_epoch_q <= 32'd0;
			obj_total_q    <= 32'd0;
			byte_total_q   <= 40'd0;
			row_valid_q    <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= emit;
			if (cfg_wr && (paddr[2] == gcmbe_pkg::REG_GLOBAL_EPOCH)) begin
				global_epoch_q <= pwdata;
			end
			// Lazy clear: drop every row and both counters, adopt the epoch
			if (stale_mark) begin
				row_valid_q    <= '0;
				obj_total_q    <= 32'd0;
				byte_total_q   <= 40'd0;
				stored_epoch_q <= global_epoch_q;
			end
			if (ram_we) begin
				row_valid_q[addr_q] <= 1'b1;
			end
			if (state_q == gcmbe_pkg::ST_ADD) begin
				obj_total_q  <= obj_sat;
				byte_total_q <= byte_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == gcmbe_pkg::ST_DIV) begin
			quot_q <= prod[PROD_W-1:RECIP_SH];
		end
		if (state_q == gcmbe_pkg::ST_ADDR) begin
			addr_q     <= addr_d;
			bit_q      <= rem[JW-1:0];
			in_range_q <= in_range_d;
		end
		if (state_q == gcmbe_pkg::ST_DATA) begin
			shift_q <= word_v;
			pos_q   <= '0;
		end else if (state_q == gcmbe_pkg::ST_SCAN) begin
			shift_q <= shift_q >> 1;
			pos_q   <= pos_q + JW'(1);
		end
		if (emit) begin
			result_q <= res_d;
		end
	end

	gcmbe_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign done   = done_q;
	assign result = result_q;

	`GCMBE_ASSERT_NEXT(a_accept_busy, accept, busy)
	`GCMBE_ASSERT_NOW(a_last_idle, done_q && result_q.last && !accept, !busy)
	`GCMBE_ASSERT_NOW(a_found_no_bit, done_q && result_q.found, !result_q.bit_value)
	`GCMBE_ASSERT_NOW(a_empty_index, done_q && !result_q.found, result_q.found_index == '0)
	`GCMBE_ASSERT_NEXT(a_mark_epoch, accept && (req.req_type == gcmbe_pkg::REQ_MARK)
		&& !cfg_wr, stored_epoch_q == global_epoch_q)

endmodule

// ===== src/gcmbe_ram.sv =====
`timescale 1ns / 1ps
module gcmbe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
